>>> rtl/tdc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tdc_pkg
// Shared types and constants of the clamped-border 2-D convolution block.
// ---------------------------------------------------------------------------
package tdc_pkg;

  localparam int MAX_KERNEL   = 7;
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MAX_CHANNELS = 4;
  localparam int LINE_DEPTH   = MAX_KERNEL * MAX_WIDTH * MAX_CHANNELS;
  localparam int LINE_AW      = $clog2(LINE_DEPTH);
  localparam int COEF_DEPTH   = MAX_KERNEL * MAX_KERNEL;
  localparam int COEF_AW      = $clog2(COEF_DEPTH);
  localparam int PIXEL_MAX    = 255;
  localparam int FRAC_BITS    = 12;
  localparam int SETTLE_CYCLES = 5;

  typedef enum logic [1:0] {
    OP_COEF   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_DRAIN  = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_CHAN   = 2'd2,
    REG_KSIZE  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_SETTLE,
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic [10:0] width;
    logic [12:0] height;
    logic [2:0]  chan;
    logic [2:0]  ksize;
  } cfg_t;

  typedef struct packed {
    logic coef_we;
    logic sample_we;
    logic start;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sample_ok;
    logic emit_sample;
    logic emit_drain;
    logic last_tap;
    logic pipe_busy;
    logic out_full;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/tdc_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tdc_in_if / tdc_out_if
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface tdc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [5:0]         coef_index;
  logic signed [15:0] coef_value;
  logic [7:0]         sample_value;

  modport source (output valid, opcode, coef_index, coef_value, sample_value, input ready);
  modport sink   (input valid, opcode, coef_index, coef_value, sample_value, output ready);
endinterface

interface tdc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered_value;
  logic       frame_done;

  modport source (output valid, filtered_value, frame_done, input ready);
  modport sink   (input valid, filtered_value, frame_done, output ready);
endinterface
`default_nettype wire

>>> rtl/tdc_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tdc_ctrl
// Sequencer: takes items, starts and steps the tap walk, hands off results.
// ---------------------------------------------------------------------------
module tdc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               in_valid_i,
  input  wire logic [1:0]         in_opcode_i,
  output logic                    in_ready_o,
  input  wire tdc_pkg::dp_status_t sts_i,
  output tdc_pkg::ctrl_cmd_t      cmd_o
);
  import tdc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [2:0]  settle_q, settle_d;
  logic        take;
  opcode_e     op;

  assign op   = opcode_e'(in_opcode_i);
  assign take = (state_q == ST_IDLE) && in_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SETTLE: if (settle_q == 3'(SETTLE_CYCLES - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (take && op == OP_SAMPLE && sts_i.emit_sample) state_d = ST_RUN;
        if (take && op == OP_DRAIN && sts_i.emit_drain) state_d = ST_RUN;
      end
      ST_RUN:    if (sts_i.last_tap) state_d = ST_FLUSH;
      ST_FLUSH:  if (!sts_i.pipe_busy) state_d = ST_FINISH;
      ST_FINISH: if (!sts_i.out_full) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
    if (cfg_we_i) state_d = ST_SETTLE;
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    settle_d   = '0;
    unique case (state_q)
      ST_SETTLE: settle_d = settle_q + 3'd1;
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.coef_we = take && op == OP_COEF;
        cmd_o.sample_we = take && op == OP_SAMPLE && sts_i.sample_ok;
        cmd_o.start   = (take && op == OP_SAMPLE && sts_i.emit_sample) ||
                        (take && op == OP_DRAIN && sts_i.emit_drain);
      end
      ST_RUN:    cmd_o.issue = 1'b1;
      ST_FLUSH:  ;
      ST_FINISH: cmd_o.finish = !sts_i.out_full;
      default:   ;
    endcase
    if (cfg_we_i) settle_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_SETTLE;
      settle_q <= '0;
    end else begin
      state_q  <= state_d;
      settle_q <= settle_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/tdc_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tdc_dp
// Datapath: line store, coefficient store, counters, tap pipeline, MAC.
// ---------------------------------------------------------------------------
module tdc_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tdc_pkg::cfg_t      cfg_i,
  input  wire logic               cfg_we_i,
  input  wire tdc_pkg::ctrl_cmd_t cmd_i,
  input  wire logic [5:0]         coef_index_i,
  input  wire logic signed [15:0] coef_value_i,
  input  wire logic [7:0]         sample_value_i,
  input  wire logic               out_ready_i,
  output tdc_pkg::dp_status_t     sts_o,
  output logic                    out_valid_o,
  output logic [7:0]              filtered_value_o,
  output logic                    frame_done_o
);
  import tdc_pkg::*;

  // clamped geometry and derived sizes
  logic [10:0] w_q;
  logic [12:0] h_q;
  logic [2:0]  c_q, k_q;
  logic [1:0]  half_q;
  logic [12:0] wc_q;
  logic [24:0] total_q;
  logic [14:0] hwc_q, delay_q;
  logic [3:0]  hc_q;

  logic [24:0] taken_q, given_q;
  logic [LINE_AW-1:0] wr_ptr_q;
  logic [1:0]  och_q;
  logic [9:0]  ocol_q;
  logic [11:0] orow_q;

  logic [2:0]  ky_q, kx_q;
  logic [COEF_AW-1:0] cidx_q;

  logic [7:0]         line_mem [LINE_DEPTH];
  logic [15:0]        coef_mem [COEF_DEPTH];
  logic [COEF_DEPTH-1:0] coef_vld_q;

  logic [11:0] y0_q;
  logic [9:0]  x0_q;
  logic [1:0]  ch0_q, ch1_q;
  logic [COEF_AW-1:0] cidx0_q, cidx1_q, cidx2_q;
  logic [24:0] yw1_q;
  logic [12:0] xc1_q;
  logic [LINE_AW-1:0] dist2_q;
  logic [7:0]  pix3_q;
  logic [15:0] coef3_q;
  logic        cv3_q;
  logic signed [24:0] prod4_q;
  logic        v0_q, v1_q, v2_q, v3_q, v4_q;
  logic signed [30:0] acc_q;

  logic        out_valid_q, frame_done_q;
  logic [7:0]  fval_q;

  always_ff @(posedge clk_i) begin
    w_q <= (cfg_i.width == '0) ? 11'd1 :
           (cfg_i.width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : cfg_i.width;
    h_q <= (cfg_i.height == '0) ? 13'd1 :
           (cfg_i.height > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : cfg_i.height;
    c_q <= (cfg_i.chan == '0) ? 3'd1 :
           (cfg_i.chan > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : cfg_i.chan;
    k_q <= (cfg_i.ksize == '0) ? 3'd1 : cfg_i.ksize;
    half_q  <= 2'(k_q >> 1);
    wc_q    <= 13'(w_q * c_q);
    total_q <= 25'(wc_q * h_q);
    hwc_q   <= 15'(half_q * wc_q);
    hc_q    <= 4'(half_q * c_q);
    delay_q <= hwc_q + 15'(hc_q);
  end

  logic signed [15:0] ysum;
  logic signed [13:0] xsum;
  logic [11:0] y_cl;
  logic [9:0]  x_cl;
  logic [24:0] s2;
  logic [LINE_AW:0] addr_wide;
  logic [LINE_AW-1:0] rd_addr;
  logic signed [30:0] shifted;

  always_comb begin
    ysum = $signed({4'b0, orow_q}) + $signed({13'b0, ky_q}) - $signed({14'b0, half_q});
    xsum = $signed({4'b0, ocol_q}) + $signed({11'b0, kx_q}) - $signed({12'b0, half_q});
    if (ysum < 0)                           y_cl = '0;
    else if (ysum >= $signed({3'b0, h_q}))  y_cl = 12'(h_q - 13'd1);
    else                                    y_cl = ysum[11:0];
    if (xsum < 0)                           x_cl = '0;
    else if (xsum >= $signed({3'b0, w_q}))  x_cl = 10'(w_q - 11'd1);
    else                                    x_cl = xsum[9:0];
    s2 = yw1_q + 25'(xc1_q) + 25'(ch1_q);
    if (wr_ptr_q >= dist2_q) addr_wide = {1'b0, wr_ptr_q - dist2_q};
    else addr_wide = {1'b0, wr_ptr_q} + (LINE_AW+1)'(LINE_DEPTH) - {1'b0, dist2_q};
    rd_addr = addr_wide[LINE_AW-1:0];
    shifted = acc_q >>> FRAC_BITS;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_we) line_mem[wr_ptr_q] <= sample_value_i;
    pix3_q <= line_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_we && coef_index_i < 6'(COEF_DEPTH))
      coef_mem[coef_index_i] <= coef_value_i;
    coef3_q <= coef_mem[cidx2_q];
    cv3_q   <= coef_vld_q[cidx2_q];
  end

  // tap pipeline payload
  always_ff @(posedge clk_i) begin
    y0_q    <= y_cl;
    x0_q    <= x_cl;
    ch0_q   <= och_q;
    cidx0_q <= cidx_q;
    yw1_q   <= 25'(y0_q * wc_q);
    xc1_q   <= 13'(x0_q * c_q);
    ch1_q   <= ch0_q;
    cidx1_q <= cidx0_q;
    dist2_q <= LINE_AW'(taken_q - s2);
    cidx2_q <= cidx1_q;
    prod4_q <= $signed({1'b0, pix3_q}) * (cv3_q ? $signed(coef3_q) : 16'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      v0_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      ky_q <= '0; kx_q <= '0; cidx_q <= '0;
      acc_q <= '0;
      taken_q <= '0; given_q <= '0; wr_ptr_q <= '0;
      och_q <= '0; ocol_q <= '0; orow_q <= '0;
      out_valid_q <= 1'b0; fval_q <= '0; frame_done_q <= 1'b0;
    end else begin
      if (cmd_i.coef_we && coef_index_i < 6'(COEF_DEPTH))
        coef_vld_q[coef_index_i] <= 1'b1;
      v0_q <= cmd_i.issue; v1_q <= v0_q; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;

      // walk the window row-major
      if (cmd_i.start) begin
        ky_q <= '0; kx_q <= '0; cidx_q <= '0;
      end else if (cmd_i.issue) begin
        cidx_q <= cidx_q + COEF_AW'(1);
        if (kx_q == k_q - 3'd1) begin
          kx_q <= '0;
          ky_q <= ky_q + 3'd1;
        end else begin
          kx_q <= kx_q + 3'd1;
        end
      end

      if (cmd_i.start)  acc_q <= '0;
      else if (v4_q)    acc_q <= acc_q + 31'(prod4_q);

      if (cmd_i.sample_we) begin
        taken_q  <= taken_q + 25'd1;
        wr_ptr_q <= (wr_ptr_q == LINE_AW'(LINE_DEPTH - 1)) ? '0 : wr_ptr_q + LINE_AW'(1);
      end

      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.finish) begin
        out_valid_q  <= 1'b1;
        fval_q       <= (shifted < 0) ? 8'd0 :
                        (shifted > 31'(PIXEL_MAX)) ? 8'(PIXEL_MAX) : shifted[7:0];
        frame_done_q <= (given_q + 25'd1 == total_q);
        given_q      <= given_q + 25'd1;
        if ({1'b0, och_q} == c_q - 3'd1) begin
          och_q <= '0;
          if ({1'b0, ocol_q} == w_q - 11'd1) begin
            ocol_q <= '0;
            orow_q <= orow_q + 12'd1;
          end else begin
            ocol_q <= ocol_q + 10'd1;
          end
        end else begin
          och_q <= och_q + 2'd1;
        end
      end

      // new geometry starts a new frame
      if (cfg_we_i) begin
        taken_q <= '0; given_q <= '0; wr_ptr_q <= '0;
        och_q <= '0; ocol_q <= '0; orow_q <= '0;
      end
    end
  end

  always_comb begin
    sts_o.sample_ok   = taken_q < total_q;
    sts_o.emit_sample = (taken_q < total_q) && (taken_q >= 25'(delay_q)) &&
                        (given_q < total_q);
    sts_o.emit_drain  = (taken_q >= total_q) && (given_q < total_q);
    sts_o.last_tap    = cmd_i.issue && (ky_q == k_q - 3'd1) && (kx_q == k_q - 3'd1);
    sts_o.pipe_busy   = v0_q | v1_q | v2_q | v3_q | v4_q;
    sts_o.out_full    = out_valid_q && !out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = fval_q;
  assign frame_done_o     = frame_done_q;

endmodule
`default_nettype wire

>>> rtl/two_d_convolution_clamped_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// two_d_convolution_clamped_top
// Streaming 2-D convolution with replicated borders, per channel.
//
//   Channel  Role     Carries
//   in_i     sink     opcode, coef_index, coef_value, sample_value
//   out_o    source   filtered_value, frame_done
//   APB      slave    image_width, image_height, channel_count, kernel_dim
//
// For an item that yields a result, one shared multiply-accumulate walks
// the K x K window, one line-store read per tap, then the five-stage tap
// pipeline drains and the result moves to the output register.
// After reset and after every register write the block settles its
// derived frame sizes before taking items.
// A stalled output holds the finished result; the next item is taken
// meanwhile, and a further result waits until the register frees up.
// ---------------------------------------------------------------------------
module two_d_convolution_clamped_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tdc_in_if.sink           in_i,
  tdc_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tdc_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_we;
  reg_idx_e   reg_idx;
  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // APB register file: write in the access phase, always ready
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= 11'd1;
      cfg_q.height <= 13'd1;
      cfg_q.chan   <= 3'd1;
      cfg_q.ksize  <= 3'd1;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_WIDTH:  cfg_q.width  <= pwdata[10:0];
        REG_HEIGHT: cfg_q.height <= pwdata[12:0];
        REG_CHAN:   cfg_q.chan   <= pwdata[2:0];
        REG_KSIZE:  cfg_q.ksize  <= pwdata[2:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = {21'b0, cfg_q.width};
      REG_HEIGHT: prdata = {19'b0, cfg_q.height};
      REG_CHAN:   prdata = {29'b0, cfg_q.chan};
      REG_KSIZE:  prdata = {29'b0, cfg_q.ksize};
      default:    prdata = '0;
    endcase
  end

  tdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tdc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cfg_we_i         (cfg_we),
    .cmd_i            (cmd),
    .coef_index_i     (in_i.coef_index),
    .coef_value_i     (in_i.coef_value),
    .sample_value_i   (in_i.sample_value),
    .out_ready_i      (out_o.ready),
    .sts_o            (sts),
    .out_valid_o      (out_o.valid),
    .filtered_value_o (out_o.filtered_value),
    .frame_done_o     (out_o.frame_done)
  );

endmodule
`default_nettype wire
